[design/apic_pending_service_vectors_defines.svh]
// Assertion macros for the pending/in-service vector block.
// Included by the RTL files that carry concurrent checks; uses clk_i and rst_ni.
`ifndef APIC_PENDING_SERVICE_VECTORS_DEFINES_SVH
`define APIC_PENDING_SERVICE_VECTORS_DEFINES_SVH
`ifndef SYNTHESIS
`define APVS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("apvs check failed");
`define APVS_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (expr)) \
    else $error("apvs check failed");
`else
`define APVS_ASSERT(name, prop)
`define APVS_ASSERT_NEXT(name, cond, expr)
`endif
`endif

[design/apvs_pkg.sv]
// Shared types, constants and the priority search for the vector block.
// No dependencies.
package apvs_pkg;

  localparam int unsigned VEC_W            = 8;
  localparam int unsigned NUM_VECS         = 256;
  localparam int unsigned WORD_W           = 32;
  localparam int unsigned NUM_WORDS        = 8;
  localparam int unsigned WORD_IDX_W       = 3;
  localparam int unsigned BIT_IDX_W        = 5;
  localparam int unsigned PRIORITY_CLASSES = 8;
  localparam int unsigned QUEUE_DEPTH      = 2;

  typedef enum logic [1:0] {
    OP_REQUEST  = 2'd0,
    OP_WIN_EXIT = 2'd1,
    OP_EOI      = 2'd2,
    OP_SPURIOUS = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_INJECT   = 3'd0,
    CMD_PEND     = 3'd1,
    CMD_EXIT     = 3'd2,
    CMD_EOI      = 3'd3,
    CMD_SPURIOUS = 3'd4,
    CMD_NONE     = 3'd5
  } cmd_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [VEC_W-1:0] vector;
    logic             window_open;
  } in_t;

  typedef struct packed {
    logic             deliver_valid;
    logic [VEC_W-1:0] deliver_vector;
    logic             exit_ctrl_valid;
    logic             exit_enable;
    logic [VEC_W-1:0] top_pending;
    logic [VEC_W-1:0] top_in_service;
    logic             pending_empty;
    logic             in_service_empty;
  } out_t;

  typedef struct packed {
    cmd_e             kind;
    logic [VEC_W-1:0] vector;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic             has;
    logic [VEC_W-1:0] vec;
  } top_t;

  function automatic top_t top_find(input logic [NUM_VECS-1:0] set,
                                    input logic [WORD_IDX_W-1:0] low_word);
    logic                  found;
    logic [WORD_IDX_W-1:0] w_sel;
    logic [BIT_IDX_W-1:0]  b_sel;
    logic [WORD_W-1:0]     word;
    top_t                  r;
    found = 1'b0;
    w_sel = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (WORD_IDX_W'(w) >= low_word && set[w*WORD_W +: WORD_W] != '0) begin
        found = 1'b1;
        w_sel = WORD_IDX_W'(w);
      end
    end
    word  = set[{w_sel, {BIT_IDX_W{1'b0}}} +: WORD_W];
    b_sel = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (word[b]) begin
        b_sel = BIT_IDX_W'(b);
      end
    end
    r.has = found;
    r.vec = found ? {w_sel, b_sel} : '0;
    return r;
  endfunction

endpackage

[design/apvs_front.sv]
// Front end: accepts events and classifies them into execution commands.
// Depends on apvs_pkg.
module apvs_front (
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  apvs_pkg::in_t   in_data_i,
  input  logic            q_full_i,
  output apvs_pkg::q_wr_t q_wr_o
);

  apvs_pkg::cmd_t cmd;

  always_comb begin
    cmd.vector = in_data_i.vector;
    case (apvs_pkg::op_e'(in_data_i.opcode))
      apvs_pkg::OP_REQUEST: begin
        cmd.kind = in_data_i.window_open ? apvs_pkg::CMD_INJECT : apvs_pkg::CMD_PEND;
      end
      apvs_pkg::OP_WIN_EXIT: begin
        cmd.kind = apvs_pkg::CMD_EXIT;
      end
      apvs_pkg::OP_EOI: begin
        cmd.kind = apvs_pkg::CMD_EOI;
      end
      apvs_pkg::OP_SPURIOUS: begin
        cmd.kind = in_data_i.window_open ? apvs_pkg::CMD_SPURIOUS : apvs_pkg::CMD_NONE;
      end
      default: begin
        cmd.kind = apvs_pkg::CMD_NONE;
      end
    endcase
  end

  assign in_stall_o  = q_full_i;
  assign q_wr_o.push = in_valid_i && !q_full_i;
  assign q_wr_o.cmd  = cmd;

endmodule

[design/apvs_queue.sv]
// Short command queue between the front end and the execution back end.
// Depends on apvs_pkg.
module apvs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  apvs_pkg::q_wr_t q_wr_i,
  output logic            full_o,
  output logic            valid_o,
  output apvs_pkg::cmd_t  cmd_o,
  input  logic            pop_i
);

  localparam int unsigned Depth = apvs_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  apvs_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (q_wr_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (q_wr_i.push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!q_wr_i.push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_wr_i.push) begin
      mem_q[wr_ptr_q] <= q_wr_i.cmd;
    end
  end

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

endmodule

[design/apvs_back.sv]
// Back end: executes commands on the pending and in-service sets and reports.
// Depends on apvs_pkg and apic_pending_service_vectors_defines.svh.
`include "apic_pending_service_vectors_defines.svh"

module apvs_back #(
  parameter int unsigned PriorityClasses = apvs_pkg::PRIORITY_CLASSES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  apvs_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output apvs_pkg::out_t out_data_o
);

  localparam logic [apvs_pkg::WORD_IDX_W-1:0] LowWord =
    apvs_pkg::WORD_IDX_W'(apvs_pkg::NUM_WORDS - PriorityClasses);

  typedef struct packed {
    logic                       deliver_valid;
    logic [apvs_pkg::VEC_W-1:0] deliver_vector;
    logic                       exit_ctrl_valid;
    logic                       exit_enable;
    logic                       exit_from_pending;
  } pend_t;

  logic [apvs_pkg::NUM_VECS-1:0] irr_q, irr_d, isr_q, isr_d;
  apvs_pkg::top_t top_p, top_s;
  pend_t          pend_q, pend_d;
  logic           pend_valid_q, pend_valid_d;
  logic           out_valid_q;
  apvs_pkg::out_t out_q;
  logic           out_free, pend_move, exec;

  assign top_p = apvs_pkg::top_find(irr_q, LowWord);
  assign top_s = apvs_pkg::top_find(isr_q, LowWord);

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pend_move = pend_valid_q && out_free;
  assign exec      = cmd_valid_i && (!pend_valid_q || pend_move);
  assign cmd_pop_o = exec;

  always_comb begin
    irr_d  = irr_q;
    isr_d  = isr_q;
    pend_d = '0;
    case (cmd_i.kind)
      apvs_pkg::CMD_INJECT: begin
        irr_d[cmd_i.vector]   = 1'b0;
        isr_d[cmd_i.vector]   = 1'b1;
        pend_d.deliver_valid  = 1'b1;
        pend_d.deliver_vector = cmd_i.vector;
      end
      apvs_pkg::CMD_PEND: begin
        irr_d[cmd_i.vector]    = 1'b1;
        pend_d.exit_ctrl_valid = 1'b1;
        pend_d.exit_enable     = 1'b1;
      end
      apvs_pkg::CMD_EXIT: begin
        if (top_p.has) begin
          irr_d[top_p.vec]      = 1'b0;
          isr_d[top_p.vec]      = 1'b1;
          pend_d.deliver_valid  = 1'b1;
          pend_d.deliver_vector = top_p.vec;
        end
        pend_d.exit_ctrl_valid   = 1'b1;
        pend_d.exit_from_pending = 1'b1;
      end
      apvs_pkg::CMD_EOI: begin
        if (top_s.has) begin
          isr_d[top_s.vec] = 1'b0;
        end
      end
      apvs_pkg::CMD_SPURIOUS: begin
        pend_d.deliver_valid  = 1'b1;
        pend_d.deliver_vector = cmd_i.vector;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (exec) begin
      pend_valid_d = 1'b1;
    end else if (pend_move) begin
      pend_valid_d = 1'b0;
    end else begin
      pend_valid_d = pend_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irr_q        <= '0;
      isr_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (exec) begin
        irr_q <= irr_d;
        isr_q <= isr_d;
      end
      pend_valid_q <= pend_valid_d;
      if (out_free) begin
        out_valid_q <= pend_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      pend_q <= pend_d;
    end
    if (pend_move) begin
      out_q.deliver_valid    <= pend_q.deliver_valid;
      out_q.deliver_vector   <= pend_q.deliver_vector;
      out_q.exit_ctrl_valid  <= pend_q.exit_ctrl_valid;
      out_q.exit_enable      <= pend_q.exit_from_pending ? top_p.has : pend_q.exit_enable;
      out_q.top_pending      <= top_p.vec;
      out_q.top_in_service   <= top_s.vec;
      out_q.pending_empty    <= !top_p.has;
      out_q.in_service_empty <= !top_s.has;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `APVS_ASSERT_NEXT(a_pend_reaches_out, pend_move, out_valid_q)
  `APVS_ASSERT(a_quiet_vector, out_valid_q && !out_q.deliver_valid |-> out_q.deliver_vector == '0)
  `APVS_ASSERT(a_enable_has_ctrl, out_valid_q && out_q.exit_enable |-> out_q.exit_ctrl_valid)
  `APVS_ASSERT(a_empty_top_zero, out_valid_q && out_q.pending_empty |-> out_q.top_pending == '0)
  `APVS_ASSERT(a_no_exec_when_blocked, pend_valid_q && !out_free |-> !exec)

endmodule

[design/apic_pending_service_vectors.sv]
// Top level of the pending/in-service vector block: front end, queue, back end.
// Depends on apvs_pkg, apvs_front, apvs_queue and apvs_back.
//
// Sustains one event per clock when neither side stalls: each event is decoded
// into a command, written to a two-entry queue, executed on the 256-bit pending
// and in-service sets into the pending register, then moved to the result
// register and reported from there. The rate is set by the single
// 256-bit priority search per set, shared by execution of the next command and
// the report of the current one. Either side may stall independently; the
// queue and the result register absorb the difference.
module apic_pending_service_vectors #(
  parameter int unsigned PriorityClasses = apvs_pkg::PRIORITY_CLASSES
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  apvs_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output apvs_pkg::out_t out_data_o
);

  apvs_pkg::q_wr_t q_wr;
  apvs_pkg::cmd_t  q_cmd;
  logic            q_full, q_valid, q_pop;

  apvs_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_wr_o     (q_wr)
  );

  apvs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_wr_i  (q_wr),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  apvs_back #(
    .PriorityClasses (PriorityClasses)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[bench/apic_pending_service_vectors_tb.sv]
// Self-checking bench for apic_pending_service_vectors: a directed table, then random events,
// each report checked against its typed row or a model of the pending and in-service sets.
// Depends on apvs_pkg and the apic_pending_service_vectors RTL.
module apic_pending_service_vectors_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VEC_W      = apvs_pkg::VEC_W;
  localparam int unsigned NUM_VECS   = apvs_pkg::NUM_VECS;
  localparam int unsigned CLASSES    = apvs_pkg::PRIORITY_CLASSES;
  localparam int unsigned SCAN_WORDS = (CLASSES < 1) ? 1 : ((CLASSES > 8) ? 8 : CLASSES);
  localparam int unsigned LOW_VEC    = (8 - SCAN_WORDS) * 32;
  localparam int unsigned RANDOM_EVENTS = 800;

  typedef enum logic [2:0] {
    PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE
  } phase_e;

  typedef struct packed {
    apvs_pkg::in_t  item;
    logic           typed;
    apvs_pkg::out_t exp;
  } case_row_t;

  typedef struct {
    apvs_pkg::in_t  item;
    logic           typed;
    apvs_pkg::out_t exp;
    phase_e         phase;
  } stim_t;

  localparam apvs_pkg::out_t NO_REPORT = '0;

  localparam case_row_t DIRECTED [25] = '{
    '{'{apvs_pkg::OP_EOI, 8'd0, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd0, 1'b1}, 1'b1,
      '{1'b0, 8'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{apvs_pkg::OP_SPURIOUS, 8'd255, 1'b1}, 1'b1,
      '{1'b1, 8'd255, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{apvs_pkg::OP_SPURIOUS, 8'd255, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1}},
    '{'{apvs_pkg::OP_REQUEST, 8'd255, 1'b0}, 1'b1,
      '{1'b0, 8'd0, 1'b1, 1'b1, 8'd255, 8'd0, 1'b0, 1'b1}},
    '{'{apvs_pkg::OP_REQUEST,  8'd0,   1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd0,   1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd255, 1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd0,   1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_EOI,      8'd0,   1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_EOI,      8'd255, 1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_EOI,      8'd0,   1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd0,   1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd128, 1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd128, 1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd128, 1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd31,  1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd32,  1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_REQUEST,  8'd224, 1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd0,   1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd0,   1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_SPURIOUS, 8'd0,   1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_SPURIOUS, 8'd170, 1'b0}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_EOI,      8'd85,  1'b1}, 1'b0, NO_REPORT},
    '{'{apvs_pkg::OP_WIN_EXIT, 8'd0,   1'b0}, 1'b0, NO_REPORT}
  };

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_stall_o;
  apvs_pkg::in_t  in_data_i   = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  apvs_pkg::out_t out_data_o;

  logic [NUM_VECS-1:0] pending_set = '0;
  logic [NUM_VECS-1:0] service_set = '0;

  stim_t          event_script[$];
  apvs_pkg::out_t expected_reports[$];
  stim_t          on_bus;
  apvs_pkg::out_t predicted;
  apvs_pkg::out_t want;
  phase_e         idle_phase = PH_STEADY;
  int unsigned    hold_cycles;
  logic           pressure_started;
  int unsigned    mismatch_count = 0;

  apic_pending_service_vectors #(
    .PriorityClasses(CLASSES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [VEC_W:0] highest_vector(input logic [NUM_VECS-1:0] set);
    logic [VEC_W:0] hit;
    hit = '0;
    for (int v = LOW_VEC; v < NUM_VECS; v++) begin
      if (set[v]) begin
        hit = {1'b1, VEC_W'(v)};
      end
    end
    return hit;
  endfunction

  function automatic apvs_pkg::op_e pick_op(input int unsigned r, input int unsigned req_max,
                                            input int unsigned exit_max);
    if (r < req_max) begin
      return apvs_pkg::OP_REQUEST;
    end else if (r < exit_max) begin
      return apvs_pkg::OP_WIN_EXIT;
    end else if (r < 90) begin
      return apvs_pkg::OP_EOI;
    end
    return apvs_pkg::OP_SPURIOUS;
  endfunction

  task automatic predict_event(input apvs_pkg::in_t ev, output apvs_pkg::out_t res);
    logic [VEC_W:0] hit;
    res = '0;
    case (apvs_pkg::op_e'(ev.opcode))
      apvs_pkg::OP_REQUEST: begin
        if (ev.window_open) begin
          pending_set[ev.vector] = 1'b0;
          service_set[ev.vector] = 1'b1;
          res.deliver_valid      = 1'b1;
          res.deliver_vector     = ev.vector;
        end else begin
          pending_set[ev.vector] = 1'b1;
          res.exit_ctrl_valid    = 1'b1;
          res.exit_enable        = 1'b1;
        end
      end
      apvs_pkg::OP_WIN_EXIT: begin
        hit = highest_vector(pending_set);
        if (hit[VEC_W]) begin
          pending_set[hit[VEC_W-1:0]] = 1'b0;
          service_set[hit[VEC_W-1:0]] = 1'b1;
          res.deliver_valid           = 1'b1;
          res.deliver_vector          = hit[VEC_W-1:0];
        end
        hit = highest_vector(pending_set);
        res.exit_ctrl_valid = 1'b1;
        res.exit_enable     = hit[VEC_W];
      end
      apvs_pkg::OP_EOI: begin
        hit = highest_vector(service_set);
        if (hit[VEC_W]) begin
          service_set[hit[VEC_W-1:0]] = 1'b0;
        end
      end
      default: begin
        if (ev.window_open) begin
          res.deliver_valid  = 1'b1;
          res.deliver_vector = ev.vector;
        end
      end
    endcase
    hit = highest_vector(pending_set);
    res.top_pending   = hit[VEC_W-1:0];
    res.pending_empty = !hit[VEC_W];
    hit = highest_vector(service_set);
    res.top_in_service   = hit[VEC_W-1:0];
    res.in_service_empty = !hit[VEC_W];
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp, act);
      mismatch_count++;
    end
  endtask

  // Sender: hold a stalled transfer, advance on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_event(on_bus.item, predicted);
        expected_reports.push_back(on_bus.typed ? on_bus.exp : predicted);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (event_script.size() != 0 &&
            $urandom_range(0, 99) >= ((event_script[0].phase == PH_SEND_IDLE) ? 63 :
                                      (event_script[0].phase == PH_BOTH) ? 7 : 0)) begin
          on_bus = event_script.pop_front();
          in_data_i  <= on_bus.item;
          in_valid_i <= 1'b1;
          idle_phase <= on_bus.phase;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: one long hold during the pressure phase, random stalls in the receive-stall and both phases.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i      <= 1'b0;
      hold_cycles      = 0;
      pressure_started = 1'b0;
    end else begin
      if (idle_phase == PH_PRESSURE && !pressure_started) begin
        pressure_started = 1'b1;
        hold_cycles      = 64;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= $urandom_range(0, 99) < ((idle_phase == PH_RECV_STALL) ? 63 :
                                                (idle_phase == PH_BOTH) ? 7 : 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report, expected none, actual %h", $time, out_data_o);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("deliver_valid", want.deliver_valid, out_data_o.deliver_valid);
        check_field("deliver_vector", want.deliver_vector, out_data_o.deliver_vector);
        check_field("exit_ctrl_valid", want.exit_ctrl_valid, out_data_o.exit_ctrl_valid);
        check_field("exit_enable", want.exit_enable, out_data_o.exit_enable);
        check_field("top_pending", want.top_pending, out_data_o.top_pending);
        check_field("top_in_service", want.top_in_service, out_data_o.top_in_service);
        check_field("pending_empty", want.pending_empty, out_data_o.pending_empty);
        check_field("in_service_empty", want.in_service_empty, out_data_o.in_service_empty);
      end
    end
  end

  initial begin
    stim_t         s;
    int unsigned   mix;
    int unsigned   r;
    apvs_pkg::op_e op;
    logic          win;
    for (int i = 0; i < $size(DIRECTED); i++) begin
      s.item  = DIRECTED[i].item;
      s.typed = DIRECTED[i].typed;
      s.exp   = DIRECTED[i].exp;
      s.phase = PH_STEADY;
      event_script.push_back(s);
    end
    mix = 0;
    for (int i = 0; i < RANDOM_EVENTS; i++) begin
      if (i % 50 == 0) begin
        mix = $urandom_range(0, 2);
      end
      r   = $urandom_range(0, 99);
      win = 1'($urandom_range(0, 1));
      case (mix)
        0: begin
          op = pick_op(r, 60, 75);
          if (op == apvs_pkg::OP_REQUEST) begin
            win = ($urandom_range(0, 9) == 0);
          end
        end
        1: op = pick_op(r, 15, 55);
        default: op = apvs_pkg::op_e'($urandom_range(0, 3));
      endcase
      s.item.opcode      = op;
      s.item.window_open = win;
      s.item.vector      = ($urandom_range(0, 7) == 0) ?
                           ($urandom_range(0, 1) ? 8'd255 : 8'd0) : 8'($urandom_range(0, 255));
      s.typed = 1'b0;
      s.exp   = '0;
      if (i >= 400 && i < 480) begin
        s.phase = PH_PRESSURE;
      end else begin
        case ((i / 100) % 4)
          0: s.phase = PH_STEADY;
          1: s.phase = PH_SEND_IDLE;
          2: s.phase = PH_RECV_STALL;
          default: s.phase = PH_BOTH;
        endcase
      end
      event_script.push_back(s);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (event_script.size() != 0 || in_valid_i) @(negedge clk_i);
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[apic_pending_service_vectors.f]
+incdir+design
design/apvs_pkg.sv
design/apvs_front.sv
design/apvs_queue.sv
design/apvs_back.sv
design/apic_pending_service_vectors.sv
bench/apic_pending_service_vectors_tb.sv
